@@ src/altitude_palette_colormap_defines.svh @@
// assertion macros shared by the colormap block
`ifndef ALTITUDE_PALETTE_COLORMAP_DEFINES_SVH
`define ALTITUDE_PALETTE_COLORMAP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define APC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define APC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/apc_pkg.sv @@
package apc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MAX_HEIGHT    = 3'd0;
  localparam logic [2:0] REG_COLOR_DEEP    = 3'd1;
  localparam logic [2:0] REG_COLOR_SHALLOW = 3'd2;
  localparam logic [2:0] REG_COLOR_LEVEL   = 3'd3;
  localparam logic [2:0] REG_COLOR_MID     = 3'd4;
  localparam logic [2:0] REG_COLOR_PEAK    = 3'd5;

  localparam int HEIGHT_W = 16;
  localparam int COLOR_W  = 24;
  localparam int CHAN_W   = 8;
  localparam int CHANNELS = 3;

  // one quotient bit per cell of the divider chain
  localparam int DIV_STEPS = 16;

  // accept edge to strobe cycle: front stage, divider cells, two blend stages
  localparam int LATENCY = DIV_STEPS + 3;

  // state handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                neg;
    logic                outer;
    logic                sat;
    logic [HEIGHT_W-1:0] rem;
    logic [HEIGHT_W-1:0] quot;
  } cell_t;

endpackage

@@ src/altitude_palette_colormap.sv @@
// altitude palette colormap: signed altitude in, blended RGB888 colour out
//
// request channel: altitude is taken at a rising edge with start high and
// busy low. busy is never raised, so one request may enter every cycle.
// result channel: rgb_color is shown for one cycle with done high; it is
// taken at the edge that ends that cycle and cannot be held off.
// pipeline: a request passes through one stage for magnitude and segment,
// sixteen divider cells (one quotient bit each), a multiply stage and an
// add stage.
// throughput: one request per cycle, set by the chain of divider cells.
// configuration: cfg_we writes cfg_data into register cfg_index (0 max
// height, 1 deep, 2 shallow, 3 level, 4 mid, 5 peak); the user must make writes
// only while no request is in flight, the block does not enforce it. other indexes are ignored.
// reset: rst, synchronous, empties the pipeline and sets max height to one
// and all colours to black.
`include "altitude_palette_colormap_defines.svh"

module altitude_palette_colormap
  import apc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [HEIGHT_W-1:0] altitude,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [COLOR_W-1:0]         cfg_data,
  output logic                       done,
  output logic [COLOR_W-1:0]         rgb_color
);

  logic [HEIGHT_W-1:0] max_height;
  logic [COLOR_W-1:0]  color_deep;
  logic [COLOR_W-1:0]  color_shallow;
  logic [COLOR_W-1:0]  color_level;
  logic [COLOR_W-1:0]  color_mid;
  logic [COLOR_W-1:0]  color_peak;
  logic [HEIGHT_W-1:0] mx;
  logic                accept;
  cell_t               stage [DIV_STEPS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // a zero max height acts as one
  assign mx = (max_height == '0) ? HEIGHT_W'(1) : max_height;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_height    <= HEIGHT_W'(1);
      color_deep    <= '0;
      color_shallow <= '0;
      color_level   <= '0;
      color_mid     <= '0;
      color_peak    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_HEIGHT:    max_height    <= cfg_data[HEIGHT_W-1:0];
        REG_COLOR_DEEP:    color_deep    <= cfg_data;
        REG_COLOR_SHALLOW: color_shallow <= cfg_data;
        REG_COLOR_LEVEL:   color_level   <= cfg_data;
        REG_COLOR_MID:     color_mid     <= cfg_data;
        REG_COLOR_PEAK:    color_peak    <= cfg_data;
        default: ;
      endcase
    end
  end

  apc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .altitude (altitude),
    .mx       (mx),
    .dout     (stage[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    apc_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[g]),
      .mx   (mx),
      .dout (stage[g+1])
    );
  end

  apc_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .din           (stage[DIV_STEPS]),
    .color_deep    (color_deep),
    .color_shallow (color_shallow),
    .color_level   (color_level),
    .color_mid     (color_mid),
    .color_peak    (color_peak),
    .done          (done),
    .rgb_color     (rgb_color)
  );

  // every request gives exactly one result after the fixed latency
  `APC_ASSERT_IMP(a_req_gives_result, clk, rst, accept, ##LATENCY done, "request lost")
  `APC_ASSERT_IMP(a_result_has_req, clk, rst, done, $past(accept, LATENCY), "spurious result")
  `APC_ASSERT_NEXT(a_front_follows_req, clk, rst, accept, stage[0].valid, "front stage missed")

endmodule

@@ src/apc_front.sv @@
module apc_front
  import apc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic signed [HEIGHT_W-1:0] altitude,
  input  logic        [HEIGHT_W-1:0] mx,
  output cell_t                      dout
);

  logic                neg;
  logic [HEIGHT_W-1:0] mag;
  logic [HEIGHT_W:0]   twice;
  logic                outer;
  logic [HEIGHT_W:0]   num;
  logic                sat;

  // magnitude, segment pick and saturation test
  always_comb begin
    neg   = altitude[HEIGHT_W-1];
    mag   = neg ? (HEIGHT_W'(0) - altitude) : altitude;
    twice = {mag, 1'b0};
    outer = twice >= {1'b0, mx};
    num   = outer ? (twice - {1'b0, mx}) : twice;
    sat   = num >= {1'b0, mx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= accept;
    end
    dout.neg   <= neg;
    dout.outer <= outer;
    dout.sat   <= sat;
    dout.rem   <= sat ? '0 : num[HEIGHT_W-1:0];
    dout.quot  <= '0;
  end

endmodule

@@ src/apc_cell.sv @@
module apc_cell
  import apc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_t               din,
  input  logic [HEIGHT_W-1:0] mx,
  output cell_t               dout
);

  logic [HEIGHT_W:0] shifted;
  logic              ge;

  // one restoring division step
  always_comb begin
    shifted = {din.rem, 1'b0};
    ge      = shifted >= {1'b0, mx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.neg   <= din.neg;
    dout.outer <= din.outer;
    dout.sat   <= din.sat;
    dout.rem   <= ge ? HEIGHT_W'(shifted - {1'b0, mx}) : shifted[HEIGHT_W-1:0];
    dout.quot  <= {din.quot[HEIGHT_W-2:0], ge};
  end

endmodule

@@ src/apc_blend.sv @@
module apc_blend
  import apc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_t              din,
  input  logic [COLOR_W-1:0] color_deep,
  input  logic [COLOR_W-1:0] color_shallow,
  input  logic [COLOR_W-1:0] color_level,
  input  logic [COLOR_W-1:0] color_mid,
  input  logic [COLOR_W-1:0] color_peak,
  output logic               done,
  output logic [COLOR_W-1:0] rgb_color
);

  localparam int W_W    = HEIGHT_W + 1;
  localparam int DIFF_W = CHAN_W + 1;
  localparam int PROD_W = W_W + 1 + DIFF_W;
  localparam int SUM_W  = PROD_W - HEIGHT_W;

  logic [W_W-1:0]     w;
  logic [COLOR_W-1:0] c1;
  logic [COLOR_W-1:0] c2;
  logic signed [DIFF_W-1:0] diff [CHANNELS];
  logic signed [PROD_W-1:0] prod [CHANNELS];

  logic                     valid_a;
  logic signed [PROD_W-1:0] prod_a [CHANNELS];
  logic [CHAN_W-1:0]        base_a [CHANNELS];
  logic signed [SUM_W-1:0]  sum    [CHANNELS];
  logic [COLOR_W-1:0]       rgb_next;

  // weight and stop colours of the chosen segment
  always_comb begin
    w = din.sat ? W_W'(1) << HEIGHT_W : {1'b0, din.quot};
    if (din.neg) begin
      c1 = din.outer ? color_shallow : color_level;
      c2 = din.outer ? color_deep : color_shallow;
    end else begin
      c1 = din.outer ? color_mid : color_level;
      c2 = din.outer ? color_peak : color_mid;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      diff[i] = $signed({1'b0, c2[i*CHAN_W +: CHAN_W]})
              - $signed({1'b0, c1[i*CHAN_W +: CHAN_W]});
      prod[i] = $signed({2'b00, w}) * diff[i];
    end
  end

  // register the products
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= din.valid;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      prod_a[i] <= prod[i];
      base_a[i] <= c1[i*CHAN_W +: CHAN_W];
    end
  end

  // start colour plus the floored weighted step
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      sum[i] = $signed({{(SUM_W-CHAN_W){1'b0}}, base_a[i]})
             + $signed(prod_a[i][PROD_W-1:HEIGHT_W]);
      rgb_next[i*CHAN_W +: CHAN_W] = sum[i][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_a;
    end
    rgb_color <= rgb_next;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import apc_pkg::*;

  // indexes past the last register, writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int MAX_GAP     = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic signed [HEIGHT_W-1:0] alt;
    int unsigned                gap;
  } height_req_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [HEIGHT_W-1:0] altitude = '0;
  logic                       cfg_we = 1'b0;
  logic [2:0]                 cfg_index = '0;
  logic [COLOR_W-1:0]         cfg_data = '0;
  logic                       done;
  logic [COLOR_W-1:0]         rgb_color;

  // pending requests and colours still owed by the block
  height_req_t        pending_reqs[$];
  logic [COLOR_W-1:0] colour_due[$];
  logic [COLOR_W-1:0] want;
  int unsigned        faults = 0;

  // local copy of the palette registers
  logic [HEIGHT_W-1:0] ht_max = 16'd1;
  logic [COLOR_W-1:0]  pal_deep = '0;
  logic [COLOR_W-1:0]  pal_shallow = '0;
  logic [COLOR_W-1:0]  pal_level = '0;
  logic [COLOR_W-1:0]  pal_mid = '0;
  logic [COLOR_W-1:0]  pal_peak = '0;

  altitude_palette_colormap u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .altitude  (altitude),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .rgb_color (rgb_color)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // colour for one altitude under the current palette
  function automatic logic [COLOR_W-1:0] colour_for(logic signed [HEIGHT_W-1:0] alt);
    logic               neg;
    logic [16:0]        mag;
    logic [16:0]        span;
    logic [17:0]        twice;
    logic               outer;
    logic [17:0]        num;
    logic [33:0]        w;
    logic [COLOR_W-1:0] lo_stop;
    logic [COLOR_W-1:0] hi_stop;
    logic [COLOR_W-1:0] mix;
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        v;
    neg = alt[HEIGHT_W-1];
    // most negative altitude keeps its full magnitude
    mag = neg ? 17'h10000 - {1'b0, alt} : {1'b0, alt};
    // zero height behaves as a height of one
    span = (ht_max == '0) ? 17'd1 : {1'b0, ht_max};
    twice = {mag, 1'b0};
    outer = twice >= {1'b0, span};
    num = outer ? twice - {1'b0, span} : twice;
    w = {num, 16'h0} / {17'b0, span};
    // weight past one pins to the outer stop
    if (w > 34'h10000) w = 34'h10000;
    if (neg) begin
      lo_stop = outer ? pal_shallow : pal_level;
      hi_stop = outer ? pal_deep : pal_shallow;
    end else begin
      lo_stop = outer ? pal_mid : pal_level;
      hi_stop = outer ? pal_peak : pal_mid;
    end
    mix = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      a = 32'(lo_stop[ch*CHAN_W +: CHAN_W]);
      b = 32'(hi_stop[ch*CHAN_W +: CHAN_W]);
      v = ((32'h10000 - w[31:0]) * a + w[31:0] * b) >> 16;
      mix[ch*CHAN_W +: CHAN_W] = v[CHAN_W-1:0];
    end
    return mix;
  endfunction

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= MAX_REPORTS) $display("%s", msg);
  endtask

  // request driver: optional gap, then hold start until taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      altitude <= '0;
    end else if (!start || !busy) begin
      if (pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else if (pending_reqs[0].gap != 0) begin
        start <= 1'b0;
        pending_reqs[0].gap--;
      end else begin
        start <= 1'b1;
        altitude <= pending_reqs[0].alt;
        void'(pending_reqs.pop_front());
      end
    end
  end

  // monitor: check results, predict taken requests, track register writes
  always @(posedge clk) begin
    if (rst) begin
      ht_max = 16'd1;
      pal_deep = '0;
      pal_shallow = '0;
      pal_level = '0;
      pal_mid = '0;
      pal_peak = '0;
      colour_due.delete();
    end else begin
      if (done) begin
        if (colour_due.size() == 0) begin
          note_fault($sformatf("unexpected result rgb_color=%06h", rgb_color));
        end else begin
          want = colour_due.pop_front();
          if (rgb_color !== want)
            note_fault($sformatf("rgb_color mismatch: expected %06h, got %06h",
                                 want, rgb_color));
        end
      end
      if (start && !busy) colour_due.push_back(colour_for(altitude));
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_HEIGHT:    ht_max = cfg_data[HEIGHT_W-1:0];
          REG_COLOR_DEEP:    pal_deep = cfg_data;
          REG_COLOR_SHALLOW: pal_shallow = cfg_data;
          REG_COLOR_LEVEL:   pal_level = cfg_data;
          REG_COLOR_MID:     pal_mid = cfg_data;
          REG_COLOR_PEAK:    pal_peak = cfg_data;
          default: ;
        endcase
      end
    end
  end

  task automatic add_req(input logic signed [HEIGHT_W-1:0] alt, input int unsigned gap);
    height_req_t r;
    r.alt = alt;
    r.gap = gap;
    pending_reqs.push_back(r);
  endtask

  // block until no request is queued, in flight or owed
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || colour_due.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [COLOR_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_palette(input logic [COLOR_W-1:0] max_word,
                               input logic [COLOR_W-1:0] deep,
                               input logic [COLOR_W-1:0] shallow,
                               input logic [COLOR_W-1:0] level,
                               input logic [COLOR_W-1:0] mid,
                               input logic [COLOR_W-1:0] peak);
    write_reg(REG_MAX_HEIGHT, max_word);
    write_reg(REG_COLOR_DEEP, deep);
    write_reg(REG_COLOR_SHALLOW, shallow);
    write_reg(REG_COLOR_LEVEL, level);
    write_reg(REG_COLOR_MID, mid);
    write_reg(REG_COLOR_PEAK, peak);
  endtask

  // one palette setting, then mostly altitudes around the height range
  task automatic random_phase(input logic [COLOR_W-1:0] max_word,
                              input logic [COLOR_W-1:0] deep,
                              input logic [COLOR_W-1:0] shallow,
                              input logic [COLOR_W-1:0] level,
                              input logic [COLOR_W-1:0] mid,
                              input logic [COLOR_W-1:0] peak,
                              input bit with_gaps, input int n);
    int unsigned                span;
    int unsigned                reach;
    int unsigned                mag;
    logic signed [HEIGHT_W-1:0] alt;
    write_palette(max_word, deep, shallow, level, mid, peak);
    @(negedge clk);
    span = (max_word[HEIGHT_W-1:0] == '0) ? 1 : max_word[HEIGHT_W-1:0];
    reach = span + span / 4 + 2;
    if (reach > 32768) reach = 32768;
    repeat (n) begin
      if ($urandom_range(0, 3) != 0) begin
        mag = $urandom_range(0, reach);
        if ($urandom_range(0, 1) != 0) alt = HEIGHT_W'(0 - mag);
        else alt = HEIGHT_W'((mag > 32767) ? 32767 : mag);
      end else begin
        alt = HEIGHT_W'($urandom);
      end
      add_req(alt, with_gaps ? $urandom_range(0, MAX_GAP) : 0);
    end
    wait_drained();
  endtask

  initial begin
    logic signed [HEIGHT_W-1:0] probe_alts[19];
    logic [COLOR_W-1:0]         max_word;
    probe_alts = '{16'sd0, 16'sd1, -16'sd1, 16'sd24, -16'sd24, 16'sd49, -16'sd49,
                   16'sd50, -16'sd50, 16'sd51, -16'sd51, 16'sd99, -16'sd99,
                   16'sd100, -16'sd100, 16'sd101, -16'sd101, 16'sd32767, -16'sd32768};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset palette: black everywhere, height of one
    @(negedge clk);
    add_req(16'sd0, 0);
    add_req(-16'sd32768, 0);
    add_req(16'sd32767, $urandom_range(0, MAX_GAP));
    wait_drained();

    // segment edges, saturation and sign extremes at height 100
    write_palette(24'd100, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000);
    write_reg(REG_SPARE_LO, 24'hFFFFFF);
    write_reg(REG_SPARE_HI, 24'h5A5A5A);
    @(negedge clk);
    foreach (probe_alts[i]) add_req(probe_alts[i], $urandom_range(0, MAX_GAP));
    wait_drained();

    // smallest height, upper data bits set on the height write
    random_phase({8'($urandom), 16'd1}, 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 24'($urandom), 1'b1, 120);
    // largest height, full-scale colour swings, back to back requests
    random_phase({8'($urandom), 16'hFFFF}, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                 24'h000000, 24'hFFFFFF, 1'b0, 120);
    // zero height
    random_phase({8'($urandom), 16'd0}, 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 24'($urandom), 1'b1, 120);
    for (int p = 0; p < 5; p++) begin
      max_word = {8'($urandom), 16'((p % 2 != 0) ? $urandom_range(1, 65535)
                                                 : $urandom_range(1, 600))};
      random_phase(max_word, 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), 24'($urandom), p != 1, 125);
    end

    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ altitude_palette_colormap.f @@
+incdir+src
src/apc_pkg.sv
src/apc_front.sv
src/apc_cell.sv
src/apc_blend.sv
src/altitude_palette_colormap.sv
dv/tb_top.sv
